>>> src/pwc_pkg.sv
package pwc_pkg;

    localparam int OPS_W  = 32;
    localparam int MS_W   = 16;
    localparam int FRAC_W = 16;
    localparam int RATE_W = OPS_W + FRAC_W;

    localparam int IN_W   = OPS_W + MS_W;
    localparam int OUT_W  = 64;

    localparam int TC_W   = 7;
    localparam int LIM_W  = 8;
    localparam int DVS_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int WIN_OUT_W  = 7;
    localparam int WAKE_W     = 6;

    localparam int DIV_CNT_W  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREAD_COUNT     = 2'd0,
        CFG_SLOWDOWN_LIMIT   = 2'd1,
        CFG_DECREASE_DIVISOR = 2'd2,
        CFG_UNUSED           = 2'd3
    } cfg_index_t;

    localparam logic [TC_W-1:0]  TC_RESET  = 7'd64;
    localparam logic [LIM_W-1:0] LIM_RESET = 8'd1;
    localparam logic [DVS_W-1:0] DVS_RESET = 8'd32;

endpackage

>>> src/pwc_divider.sv
module pwc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pwc_pkg::RATE_W-1:0]  dividend,
    input  logic [pwc_pkg::MS_W-1:0]    divisor,
    output logic                        busy,
    output logic [pwc_pkg::RATE_W-1:0]  quotient
);
    import pwc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(RATE_W - 1);

    logic [RATE_W-1:0]    quo_reg;
    logic [RATE_W-1:0]    quo_next;
    logic [MS_W-1:0]      rem_reg;
    logic [MS_W-1:0]      rem_next;
    logic [MS_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [MS_W:0]        partial;
    logic [MS_W+1:0]      diff;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        partial = {rem_reg, quo_reg[RATE_W-1]};
        diff    = {1'b0, partial} - {2'b00, dvs_reg};
        if (!diff[MS_W+1])
        begin
            rem_next = diff[MS_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = partial[MS_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> src/pwc_history.sv
module pwc_history #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [pwc_pkg::RATE_W-1:0]    rd_rate,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [pwc_pkg::RATE_W-1:0]    wr_rate,
    input  logic                          clr_en,
    input  logic [$clog2(DEPTH)-1:0]      clr_from
);
    import pwc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [RATE_W-1:0] mem [DEPTH];
    logic [RATE_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    // An entry that was never written since reset or since it was cleared reads as zero.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (clr_en && (AW'(i) >= clr_from))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rate;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_rate = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/parallelism_window_controller.sv
// Channel   Direction  Beat fields
// s_*       in         s_tdata: ops_delta[31:0], elapsed_ms[47:32]
// m_*       out        m_tdata: window_size, wake_valid, wake_thread, rate, backing_off
// cfg_*     in         cfg_index selects the register, cfg_data carries its value
//
// A tick first divides its ops by its elapsed time to get the rate; a tick that divides
// the window down then uses the divider a second time. The bit-serial divider
// yields one quotient bit per cycle and serves both the rate and the decrease.
// History is read once on acceptance and written at most once, at the end of the tick.
// Reset clears all control state and marks every history entry empty; no sweep is needed.
// One tick is in flight at a time; a finished result may wait in the output register
// while the next tick is accepted, and the tick completes only once that slot is free.
module parallelism_window_controller #(
    parameter int MAX_THREADS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] ops_delta, [47:32] elapsed_ms
    input  logic [pwc_pkg::IN_W-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] window_size, [7] wake_valid, [13:8] wake_thread, [61:14] rate,
    // [62] backing_off, [63] zero
    output logic [pwc_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pwc_pkg::*;

    localparam int AW    = $clog2(MAX_THREADS);
    localparam int WW    = ($clog2(MAX_THREADS + 1) > WIN_OUT_W) ?
                           $clog2(MAX_THREADS + 1) : WIN_OUT_W;
    localparam int NM_W  = WW + 5;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RATE = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DEC  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [WW-1:0]     window_reg;
    logic [WW-1:0]     window_next;
    logic              probe_reg;
    logic              probe_next;
    logic [LIM_W-1:0]  slow_cnt_reg;
    logic [LIM_W-1:0]  slow_cnt_next;
    logic [RATE_W-1:0] rate_reg;
    logic [TC_W-1:0]   tc_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [OUT_W-1:0]  m_data_reg;
    logic [OUT_W-1:0]  m_data_next;

    logic              accept;
    logic              out_free;
    logic              faster;
    logic              do_dec;
    logic              do_grow;
    logic [LIM_W-1:0]  cnt_inc;
    logic [MS_W-1:0]   ms_fixed;
    logic [DVS_W-1:0]  dvs_fixed;
    logic [NM_W-1:0]   dec_num;
    logic [NM_W-1:0]   dec_q;
    logic [WW-1:0]     nm_raw;
    logic [WW-1:0]     nm;
    logic              wake;

    logic              div_start;
    logic [RATE_W-1:0] div_dividend;
    logic [MS_W-1:0]   div_divisor;
    logic              div_busy;
    logic [RATE_W-1:0] div_quotient;

    logic              hist_rd_en;
    logic [AW-1:0]     hist_rd_addr;
    logic [RATE_W-1:0] hist_rd_rate;
    logic              hist_wr_en;
    logic [AW-1:0]     hist_wr_addr;
    logic              hist_clr_en;
    logic [AW-1:0]     hist_clr_from;

    pwc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    pwc_history #(
        .DEPTH (MAX_THREADS)
    ) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (hist_rd_en),
        .rd_addr  (hist_rd_addr),
        .rd_rate  (hist_rd_rate),
        .wr_en    (hist_wr_en),
        .wr_addr  (hist_wr_addr),
        .wr_rate  (rate_reg),
        .clr_en   (hist_clr_en),
        .clr_from (hist_clr_from)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign ms_fixed  = (s_tdata[IN_W-1:OPS_W] == '0) ? MS_W'(1) : s_tdata[IN_W-1:OPS_W];
    assign dvs_fixed = (dvs_reg == '0) ? DVS_W'(1) : dvs_reg;
    assign dec_num   = (NM_W'(window_reg) + NM_W'(1)) << 4;

    assign faster  = (window_reg == WW'(1)) || (rate_reg > hist_rd_rate);
    assign cnt_inc = slow_cnt_reg + LIM_W'(1);
    assign do_dec  = !faster && probe_reg && (cnt_inc == limit_reg);
    assign do_grow = (window_reg < WW'(tc_reg)) && (window_reg < WW'(MAX_THREADS));

    assign dec_q   = div_quotient[NM_W-1:0];
    assign nm_raw  = (dec_q >= NM_W'(window_reg)) ? (window_reg - WW'(1)) : WW'(dec_q);
    assign nm      = (nm_raw == '0) ? WW'(1) : nm_raw;

    assign hist_rd_en    = accept;
    assign hist_rd_addr  = AW'(window_reg - WW'(2));
    assign hist_wr_addr  = AW'(window_reg - WW'(1));
    assign hist_clr_from = AW'(nm - WW'(1));

    always_comb
    begin
        state_next    = state_reg;
        window_next   = window_reg;
        probe_next    = probe_reg;
        slow_cnt_next = slow_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        div_dividend  = {s_tdata[OPS_W-1:0], FRAC_W'(0)};
        div_divisor   = ms_fixed;
        hist_wr_en    = 1'b0;
        hist_clr_en   = 1'b0;
        wake          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    div_start  = 1'b1;
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (do_dec)
                begin
                    div_start    = 1'b1;
                    div_dividend = RATE_W'(dec_num);
                    div_divisor  = MS_W'(dvs_fixed);
                    state_next   = ST_DEC;
                end
                else if (out_free)
                begin
                    if (faster)
                    begin
                        hist_wr_en    = !probe_reg;
                        probe_next    = 1'b0;
                        slow_cnt_next = '0;
                        if (do_grow)
                        begin
                            window_next = window_reg + WW'(1);
                            wake        = 1'b1;
                        end
                    end
                    else if (!probe_reg)
                    begin
                        window_next = window_reg - WW'(1);
                        probe_next  = 1'b1;
                    end
                    else
                    begin
                        slow_cnt_next = cnt_inc;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, probe_next, rate_reg,
                                    wake ? WAKE_W'(window_next - WW'(1)) : WAKE_W'(0),
                                    wake, window_next[WIN_OUT_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            ST_DEC:
            begin
                if (!div_busy && out_free)
                begin
                    hist_clr_en   = 1'b1;
                    window_next   = nm;
                    probe_next    = 1'b0;
                    slow_cnt_next = '0;
                    m_valid_next  = 1'b1;
                    m_data_next   = {1'b0, 1'b0, rate_reg, WAKE_W'(0), 1'b0,
                                     nm[WIN_OUT_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            window_reg   <= WW'(1);
            probe_reg    <= 1'b0;
            slow_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            tc_reg       <= TC_RESET;
            limit_reg    <= LIM_RESET;
            dvs_reg      <= DVS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            probe_reg    <= probe_next;
            slow_cnt_reg <= slow_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_THREAD_COUNT:     tc_reg    <= cfg_data[TC_W-1:0];
                    CFG_SLOWDOWN_LIMIT:   limit_reg <= cfg_data;
                    CFG_DECREASE_DIVISOR: dvs_reg   <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        if ((state_reg == ST_RATE) && !div_busy)
        begin
            rate_reg <= div_quotient;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The window stays within one thread and the thread limit of the design.
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_reg >= WW'(1)) && (window_reg <= WW'(MAX_THREADS)))
        else $error("window size out of range");

    // A woken thread is always the new top of the window.
    a_wake_top: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[13:8] == WAKE_W'(m_tdata[6:0] - 7'd1)))
        else $error("woken thread does not match window size");

    // Growth and probing never come together in one result.
    a_wake_not_probe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[7] && m_tdata[62]))
        else $error("wake reported while backing off");

    // The divider is idle whenever a new tick is taken.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !div_busy)
        else $error("tick accepted while divider busy");

endmodule
